FILE: hdl/wct_pkg.sv
// Shared types and constants for the weighted coordinate table.
// Used by wct_ctrl, wct_dp and the top level weighted_coordinate_table.
package wct_pkg;

   localparam int DEF_MAX_ENTRIES = 512;
   localparam int DEF_COORD_BITS  = 6;

   localparam int FUNC_W   = 3;
   localparam int COORD_W  = 6;
   localparam int WEIGHT_W = 32;
   localparam int BOARD_W  = 6;
   localparam int SQ_W     = 2 * BOARD_W;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 9;
   localparam int COUNT_W  = 10;

   localparam logic [BOARD_W-1:0] BOARD_RESET = 6'd19;
   localparam logic [SQ_W-1:0]    SQ_RESET    = 12'd361;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_ADD    = 3'd1,
      FUNC_SET    = 3'd2,
      FUNC_MERGE  = 3'd3,
      FUNC_REMOVE = 3'd4,
      FUNC_LOOKUP = 3'd5,
      FUNC_RANGE  = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_OFF_BOARD = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan;
      logic read_last;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip_scan;
      logic scan_done;
      logic need_last;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/wct_ctrl.sv
// Request sequencer of the weighted coordinate table.
// Depends on wct_pkg; drives the datapath wct_dp through cmd_type commands.
module wct_ctrl
   import wct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (sts.skip_scan) begin
               state_in = S_COMMIT;
            end else if (sts.scan_done) begin
               state_in = sts.need_last ? S_LAST : S_COMMIT;
            end
         end
         S_LAST: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      cmd.accept    = (state_ff == S_IDLE) && req_valid;
      cmd.scan      = (state_ff == S_SCAN);
      cmd.read_last = (state_ff == S_LAST);
      cmd.commit    = (state_ff == S_COMMIT) && sts.out_free;
   end

endmodule

FILE: hdl/wct_dp.sv
// Datapath of the weighted coordinate table: entry memory, scan pointer,
// request and result registers. Depends on wct_pkg; commanded by wct_ctrl.
module wct_dp
   import wct_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [COORD_W-1:0]         req_col,
   input  logic [COORD_W-1:0]         req_row,
   input  logic signed [WEIGHT_W-1:0] req_weight_in,
   input  logic                       csr_write,
   input  logic [BOARD_W-1:0]         csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [INDEX_W-1:0]         rsp_index,
   output logic signed [WEIGHT_W-1:0] rsp_weight_out,
   output logic signed [WEIGHT_W-1:0] rsp_min_weight,
   output logic signed [WEIGHT_W-1:0] rsp_max_weight,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int EW   = 2 * CW + WEIGHT_W;
   localparam int IDXW = $clog2(MAX_ENTRIES);
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = 16;

   logic [EW-1:0] entry_mem_ff [MAX_ENTRIES];
   logic [EW-1:0] rd_q_ff;
   logic          mem_we;
   logic          mem_re;
   logic [IDXW-1:0] mem_waddr;
   logic [IDXW-1:0] mem_raddr;
   logic [EW-1:0]   mem_wdata;

   logic [BOARD_W-1:0] board_ff, board_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [CNTW-1:0]    count_ff, count_in;

   func_type             func_ff, func_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [CW-1:0]        row_ff, row_in;
   logic signed [WEIGHT_W-1:0] w_ff, w_in;
   logic                 on_board_ff, on_board_in;
   logic                 full_ff, full_in;

   logic [CNTW-1:0]      ptr_ff, ptr_in;
   logic                 pend_ff, pend_in;
   logic [IDXW-1:0]      pend_idx_ff, pend_idx_in;
   logic                 found_ff, found_in;
   logic [IDXW-1:0]      idx_ff, idx_in;
   logic signed [WEIGHT_W-1:0] mw_ff, mw_in;
   logic                 first_ff, first_in;
   logic signed [WEIGHT_W-1:0] mn_ff, mn_in;
   logic signed [WEIGHT_W-1:0] mx_ff, mx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic signed [WEIGHT_W-1:0] rsp_wout_ff, rsp_wout_in;
   logic signed [WEIGHT_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [WEIGHT_W-1:0] rsp_max_ff, rsp_max_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [CW-1:0]        req_col_m;
   logic [CW-1:0]        req_row_m;
   logic signed [WEIGHT_W-1:0] rd_w;
   logic [CW-1:0]        rd_col;
   logic [CW-1:0]        rd_row;
   logic                 searching;
   logic                 match_now;
   logic [CNTW-1:0]      cnt_m1;
   logic signed [WEIGHT_W:0] sum;
   logic signed [WEIGHT_W-1:0] sum_sat;
   logic signed [WEIGHT_W-1:0] new_w;

   assign req_col_m = req_col[CW-1:0];
   assign req_row_m = req_row[CW-1:0];
   assign rd_w      = rd_q_ff[WEIGHT_W-1:0];
   assign rd_row    = rd_q_ff[WEIGHT_W +: CW];
   assign rd_col    = rd_q_ff[WEIGHT_W + CW +: CW];
   assign cnt_m1    = count_ff - CNTW'(1);

   assign searching = (func_ff != FUNC_RANGE);
   assign match_now = pend_ff && searching && (rd_col == col_ff) && (rd_row == row_ff);

   // Saturating add of the stored weight and the request weight.
   assign sum = {mw_ff[WEIGHT_W-1], mw_ff} + {w_ff[WEIGHT_W-1], w_ff};
   always_comb begin
      if (sum[WEIGHT_W] != sum[WEIGHT_W-1]) begin
         sum_sat = sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                 : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         sum_sat = sum[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      unique case (func_ff)
         FUNC_ADD: new_w = sum_sat;
         FUNC_SET: new_w = w_ff;
         default:  new_w = (w_ff > mw_ff) ? w_ff : mw_ff;
      endcase
   end

   always_comb begin
      sts.skip_scan = (func_ff == FUNC_CLEAR) ||
                      ((func_ff == FUNC_SET) && !on_board_ff) ||
                      !((func_ff == FUNC_ADD) || (func_ff == FUNC_SET) ||
                        (func_ff == FUNC_MERGE) || (func_ff == FUNC_REMOVE) ||
                        (func_ff == FUNC_LOOKUP) || (func_ff == FUNC_RANGE));
      sts.scan_done = match_now || (!pend_ff && (ptr_ff >= count_ff));
      sts.need_last = (func_ff == FUNC_REMOVE) && (found_ff || match_now);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      board_in      = board_ff;
      sq_in         = sq_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      w_in          = w_ff;
      on_board_in   = on_board_ff;
      full_in       = full_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      mw_in         = mw_ff;
      first_in      = first_ff;
      mn_in         = mn_ff;
      mx_in         = mx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_wout_in   = rsp_wout_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = idx_ff;
      mem_raddr     = ptr_ff[IDXW-1:0];
      mem_wdata     = {col_ff, row_ff, new_w};

      if (csr_write) begin
         board_in = csr_wdata;
         sq_in    = SQ_W'(csr_wdata) * SQ_W'(csr_wdata);
      end

      if (cmd.accept) begin
         func_in     = func_type'(req_func);
         col_in      = req_col_m;
         row_in      = req_row_m;
         w_in        = req_weight_in;
         on_board_in = (CMPW'(req_col_m) < CMPW'(board_ff)) &&
                       (CMPW'(req_row_m) < CMPW'(board_ff));
         full_in     = (CMPW'(count_ff) >= CMPW'(sq_ff)) ||
                       (CMPW'(count_ff) >= CMPW'(MAX_ENTRIES));
         ptr_in      = '0;
         pend_in     = 1'b0;
         found_in    = 1'b0;
         idx_in      = '0;
         mw_in       = '0;
         first_in    = 1'b1;
         mn_in       = '0;
         mx_in       = '0;
      end

      if (cmd.scan && !sts.skip_scan) begin
         if (pend_ff) begin
            if (match_now) begin
               found_in = 1'b1;
               idx_in   = pend_idx_ff;
               mw_in    = rd_w;
            end else if (!searching) begin
               first_in = 1'b0;
               if (first_ff || (rd_w < mn_ff)) begin
                  mn_in = rd_w;
               end
               if (first_ff || (rd_w > mx_ff)) begin
                  mx_in = rd_w;
               end
            end
         end
         if (!match_now && (ptr_ff < count_ff)) begin
            mem_re      = 1'b1;
            mem_raddr   = ptr_ff[IDXW-1:0];
            ptr_in      = ptr_ff + CNTW'(1);
            pend_in     = 1'b1;
            pend_idx_in = ptr_ff[IDXW-1:0];
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.read_last) begin
         mem_re    = 1'b1;
         mem_raddr = cnt_m1[IDXW-1:0];
      end

      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_found_in  = 1'b0;
         rsp_index_in  = '0;
         rsp_wout_in   = '0;
         rsp_min_in    = '0;
         rsp_max_in    = '0;
         unique case (func_ff)
            FUNC_CLEAR: begin
               count_in = '0;
            end
            FUNC_ADD, FUNC_SET, FUNC_MERGE: begin
               priority if ((func_ff == FUNC_SET) && !on_board_ff) begin
                  rsp_status_in = ST_OFF_BOARD;
               end else if (found_ff) begin
                  mem_we       = 1'b1;
                  mem_waddr    = idx_ff;
                  mem_wdata    = {col_ff, row_ff, new_w};
                  rsp_found_in = 1'b1;
                  rsp_index_in = INDEX_W'(idx_ff);
                  rsp_wout_in  = new_w;
               end else if ((func_ff == FUNC_MERGE) && !on_board_ff) begin
                  rsp_status_in = ST_OFF_BOARD;
               end else if (full_ff) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  mem_we       = 1'b1;
                  mem_waddr    = count_ff[IDXW-1:0];
                  mem_wdata    = {col_ff, row_ff, w_ff};
                  rsp_index_in = INDEX_W'(count_ff);
                  rsp_wout_in  = w_ff;
                  count_in     = count_ff + CNTW'(1);
               end
            end
            FUNC_REMOVE, FUNC_LOOKUP: begin
               if (!found_ff) begin
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  rsp_found_in = 1'b1;
                  rsp_index_in = INDEX_W'(idx_ff);
                  rsp_wout_in  = mw_ff;
                  if (func_ff == FUNC_REMOVE) begin
                     // The last entry was read in the S_LAST state, and rd_q_ff still holds it.
                     mem_we    = 1'b1;
                     mem_waddr = idx_ff;
                     mem_wdata = rd_q_ff;
                     count_in  = cnt_m1;
                  end
               end
            end
            FUNC_RANGE: begin
               rsp_min_in = mn_ff;
               rsp_max_in = mx_ff;
            end
            default: begin
            end
         endcase
         rsp_count_in = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q_ff <= entry_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff     <= BOARD_RESET;
         sq_ff        <= SQ_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         board_ff     <= board_in;
         sq_ff        <= sq_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      w_ff          <= w_in;
      on_board_ff   <= on_board_in;
      full_ff       <= full_in;
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      mw_ff         <= mw_in;
      first_ff      <= first_in;
      mn_ff         <= mn_in;
      mx_ff         <= mx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_wout_ff   <= rsp_wout_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_index      = rsp_index_ff;
   assign rsp_weight_out = rsp_wout_ff;
   assign rsp_min_weight = rsp_min_ff;
   assign rsp_max_weight = rsp_max_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

FILE: hdl/weighted_coordinate_table.sv
// Top level of the weighted coordinate table.
// Depends on wct_pkg and instantiates wct_ctrl and wct_dp.
//
// Channel   Direction  Handshake               Payload
// req_*     in         req_valid / req_stall   func, col, row, weight_in
// rsp_*     out        rsp_valid / rsp_stall   status, found, index, weight_out,
//                                              min_weight, max_weight, count
// csr_*     in         csr_write               board edge length (csr_wdata)
//
// A request is accepted from idle, then scans the entry memory with one read per
// stored entry, stopping at a key match, compares the registered read data as it
// arrives, reads the last entry for a remove that found its key, and commits. Clear, the
// no-op code and a set with an off-board key skip the scan. Reset is synchronous
// and active high; it empties the table and sets the board edge length to 19. The
// block takes one request at a time. A result beat waits in the output register
// while rsp_stall is high, and the next request may be accepted meanwhile; it
// then holds in its commit state until the output register frees.
module weighted_coordinate_table
   import wct_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [COORD_W-1:0]         req_col,
   input  logic [COORD_W-1:0]         req_row,
   input  logic signed [WEIGHT_W-1:0] req_weight_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [INDEX_W-1:0]         rsp_index,
   output logic signed [WEIGHT_W-1:0] rsp_weight_out,
   output logic signed [WEIGHT_W-1:0] rsp_min_weight,
   output logic signed [WEIGHT_W-1:0] rsp_max_weight,
   output logic [COUNT_W-1:0]         rsp_count,
   input  logic                       csr_write,
   input  logic [BOARD_W-1:0]         csr_wdata
);

   // The sequencer steps accept, scan, optional last-entry read and commit;
   // the datapath owns the memory and reports when the scan is finished.
   cmd_type cmd;
   sts_type sts;

   wct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The entry memory is searched linearly from slot zero, so the first
   // matching key wins, exactly as a dense table without holes requires.
   wct_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_weight_in  (req_weight_in),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_index      (rsp_index),
      .rsp_weight_out (rsp_weight_out),
      .rsp_min_weight (rsp_min_weight),
      .rsp_max_weight (rsp_max_weight),
      .rsp_count      (rsp_count)
   );

endmodule

FILE: test/tb.sv
// Self-checking testbench for weighted_coordinate_table: random and directed request beats,
// checked against an in-bench prediction of the entry table.
// Depends on wct_pkg and the weighted_coordinate_table RTL only.
module tb;
   import wct_pkg::*;

   localparam int TBL_DEPTH   = DEF_MAX_ENTRIES;
   localparam int CYCLE_LIMIT = 4_000_000;
   // Long enough for a scan over a completely full table plus its overhead.
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [FUNC_W-1:0] FUNC_NOP = 3'd7;
   localparam longint SAT_MAX = 2147483647;
   localparam longint SAT_MIN = -longint'(2147483647) - 1;

   typedef struct {
      logic [FUNC_W-1:0]          func;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [WEIGHT_W-1:0] weight;
   } table_req_type;

   typedef struct {
      status_type                 status;
      logic                       found;
      logic [INDEX_W-1:0]         index;
      logic signed [WEIGHT_W-1:0] weight;
      logic signed [WEIGHT_W-1:0] min_w;
      logic signed [WEIGHT_W-1:0] max_w;
      logic [COUNT_W-1:0]         count;
   } table_rsp_type;

   // All block inputs start at known values.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [FUNC_W-1:0]          req_func = '0;
   logic [COORD_W-1:0]         req_col = '0;
   logic [COORD_W-1:0]         req_row = '0;
   logic signed [WEIGHT_W-1:0] req_weight_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_found;
   logic [INDEX_W-1:0]         rsp_index;
   logic signed [WEIGHT_W-1:0] rsp_weight_out;
   logic signed [WEIGHT_W-1:0] rsp_min_weight;
   logic signed [WEIGHT_W-1:0] rsp_max_weight;
   logic [COUNT_W-1:0]         rsp_count;
   logic                       csr_write = 1'b0;
   logic [BOARD_W-1:0]         csr_wdata = '0;

   // Beats still to be offered, and results the table should still return, oldest first.
   table_req_type pending_reqs[$];
   table_rsp_type expected_rsps[$];

   // Shadow copy of the entry table and the board size register.
   logic [COORD_W-1:0]         tbl_col[TBL_DEPTH];
   logic [COORD_W-1:0]         tbl_row[TBL_DEPTH];
   logic signed [WEIGHT_W-1:0] tbl_weight[TBL_DEPTH];
   int                         tbl_count = 0;
   logic [BOARD_W-1:0]         board_cfg = BOARD_RESET;

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // The stimulus process bumps pressure_kicks; the receiver notices the change and
   // holds rsp_stall high for a long stretch that it counts itself.
   int pressure_kicks = 0;
   int pressure_seen = 0;
   int hold_left = 0;

   weighted_coordinate_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_weight_in  (req_weight_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_index      (rsp_index),
      .rsp_weight_out (rsp_weight_out),
      .rsp_min_weight (rsp_min_weight),
      .rsp_max_weight (rsp_max_weight),
      .rsp_count      (rsp_count),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the result it must produce.
   // The key search runs on the table as it stands before the request, and the first
   // matching slot wins.
   function automatic table_rsp_type predict_table(table_req_type rq);
      table_rsp_type rs;
      int         hit;
      int         lim;
      int         last;
      bit         on_board;
      longint     sum;
      rs.status = ST_OK;
      rs.found  = 1'b0;
      rs.index  = '0;
      rs.weight = '0;
      rs.min_w  = '0;
      rs.max_w  = '0;
      lim = int'(board_cfg) * int'(board_cfg);
      if (lim > TBL_DEPTH) begin
         lim = TBL_DEPTH;
      end
      on_board = (rq.col < board_cfg) && (rq.row < board_cfg);
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
         if (hit < 0 && tbl_col[i] == rq.col && tbl_row[i] == rq.row) begin
            hit = i;
         end
      end

      case (rq.func)
         FUNC_CLEAR: begin
            tbl_count = 0;
         end
         FUNC_ADD, FUNC_SET, FUNC_MERGE: begin
            // Set checks the board before anything else, even for an existing key.
            if (rq.func == FUNC_SET && !on_board) begin
               rs.status = ST_OFF_BOARD;
            end else if (hit >= 0) begin
               rs.found = 1'b1;
               rs.index = INDEX_W'(hit);
               if (rq.func == FUNC_ADD) begin
                  sum = longint'(tbl_weight[hit]) + longint'(rq.weight);
                  if (sum > SAT_MAX) begin
                     sum = SAT_MAX;
                  end
                  if (sum < SAT_MIN) begin
                     sum = SAT_MIN;
                  end
                  tbl_weight[hit] = sum[WEIGHT_W-1:0];
               end else if (rq.func == FUNC_SET || rq.weight > tbl_weight[hit]) begin
                  tbl_weight[hit] = rq.weight;
               end
               rs.weight = tbl_weight[hit];
            end else if (rq.func == FUNC_MERGE && !on_board) begin
               // A merge only checks the board when it would append.
               rs.status = ST_OFF_BOARD;
            end else if (tbl_count >= lim) begin
               rs.status = ST_FULL;
            end else begin
               tbl_col[tbl_count]    = rq.col;
               tbl_row[tbl_count]    = rq.row;
               tbl_weight[tbl_count] = rq.weight;
               rs.index  = INDEX_W'(tbl_count);
               rs.weight = rq.weight;
               tbl_count++;
            end
         end
         FUNC_REMOVE, FUNC_LOOKUP: begin
            if (hit < 0) begin
               rs.status = ST_NOT_FOUND;
            end else begin
               rs.found  = 1'b1;
               rs.index  = INDEX_W'(hit);
               rs.weight = tbl_weight[hit];
               if (rq.func == FUNC_REMOVE) begin
                  // The last entry fills the hole so the table stays dense.
                  last = tbl_count - 1;
                  tbl_col[hit]    = tbl_col[last];
                  tbl_row[hit]    = tbl_row[last];
                  tbl_weight[hit] = tbl_weight[last];
                  tbl_count = last;
               end
            end
         end
         FUNC_RANGE: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (i == 0 || tbl_weight[i] < rs.min_w) begin
                  rs.min_w = tbl_weight[i];
               end
               if (i == 0 || tbl_weight[i] > rs.max_w) begin
                  rs.max_w = tbl_weight[i];
               end
            end
         end
         default: begin
            // The unused code leaves the table alone.
         end
      endcase
      rs.count = COUNT_W'(tbl_count);
      return rs;
   endfunction

   function automatic void check_field(string fname, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", fname, want, got);
         errors++;
      end
   endfunction

   // Weights lean toward the two extremes and small values so that saturation and
   // merge comparisons come up often.
   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return int'($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Keys mostly come from the window 0..span, so they repeat and, where span passes the
   // board edge, straddle the on-board boundary; now and then any coordinate is drawn.
   function automatic logic [COORD_W-1:0] pick_coord(int span);
      if ($urandom_range(0, 7) == 0) begin
         return COORD_W'($urandom_range(0, 63));
      end
      return COORD_W'($urandom_range(0, span));
   endfunction

   task automatic post_req(input logic [FUNC_W-1:0] f, input logic [COORD_W-1:0] c,
                           input logic [COORD_W-1:0] r, input logic signed [WEIGHT_W-1:0] w);
      table_req_type rq;
      rq.func   = f;
      rq.col    = c;
      rq.row    = r;
      rq.weight = w;
      pending_reqs.push_back(rq);
   endtask

   // A random mix of all operations. Adds dominate so that the table grows between
   // the occasional clears.
   task automatic post_mixed(int n, int span);
      int                r;
      logic [FUNC_W-1:0] f;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            f = FUNC_CLEAR;
         end else if (r < 33) begin
            f = FUNC_ADD;
         end else if (r < 47) begin
            f = FUNC_SET;
         end else if (r < 61) begin
            f = FUNC_MERGE;
         end else if (r < 73) begin
            f = FUNC_REMOVE;
         end else if (r < 85) begin
            f = FUNC_LOOKUP;
         end else if (r < 97) begin
            f = FUNC_RANGE;
         end else begin
            f = FUNC_NOP;
         end
         post_req(f, pick_coord(span), pick_coord(span), pick_weight());
      end
   endtask

   // Returns at a falling edge once every beat has been taken and every result returned.
   // Sampling at the falling edge keeps clear of the queue updates made at the rising edge.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The register is only written while the block has nothing in flight.
   task automatic write_board(input logic [BOARD_W-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      board_cfg = v;
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Sender. A new beat is offered only once the previous one was taken; a stalled beat
   // stays on the wires unchanged.
   always @(posedge clock) begin
      table_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_valid     <= 1'b1;
            req_func      <= nxt.func;
            req_col       <= nxt.col;
            req_row       <= nxt.row;
            req_weight_in <= nxt.weight;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall. A pressure kick overrides the random stall until the hold_left countdown
   // runs out, long enough for the block to park one result and then stall its own input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_seen != pressure_kicks) begin
         pressure_seen <= pressure_kicks;
         hold_left     <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Monitor. An accepted request beat is run through the prediction at once; an
   // accepted result beat is checked against the oldest waiting prediction.
   always @(posedge clock) begin
      table_rsp_type want;
      table_req_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.func   = req_func;
            seen.col    = req_col;
            seen.row    = req_row;
            seen.weight = req_weight_in;
            expected_rsps.push_back(predict_table(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("found", want.found, rsp_found);
               check_field("index", want.index, rsp_index);
               check_field("weight_out", want.weight, rsp_weight_out);
               check_field("min_weight", want.min_w, rsp_min_weight);
               check_field("max_weight", want.max_w, rsp_max_weight);
               check_field("count", want.count, rsp_count);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                k;
      logic [FUNC_W-1:0] f;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: the sender rarely pauses and the receiver stalls more than half the time.
      send_idle_pct = 6;
      recv_idle_pct = 55;

      // Directed beats on the board size left by reset. An empty table first.
      post_req(FUNC_RANGE, 0, 0, 0);
      post_req(FUNC_LOOKUP, 3, 4, 0);
      post_req(FUNC_REMOVE, 3, 4, 0);
      // Accumulation saturating at both ends of the weight range.
      post_req(FUNC_ADD, 0, 0, 32'sh7fff_ffff);
      post_req(FUNC_ADD, 0, 0, 1);
      post_req(FUNC_ADD, 1, 1, 32'sh8000_0000);
      post_req(FUNC_ADD, 1, 1, -1);
      // Add ignores the board, so this off-board key is stored.
      post_req(FUNC_ADD, 63, 63, 5);
      post_req(FUNC_SET, 0, 0, -7);
      // Set refuses an off-board key even though it exists; merge updates it.
      post_req(FUNC_SET, 63, 63, 1);
      post_req(FUNC_MERGE, 63, 63, 3);
      post_req(FUNC_MERGE, 63, 63, 100);
      post_req(FUNC_MERGE, 2, 3, -50);
      post_req(FUNC_RANGE, 0, 0, 0);
      // Removing slot zero pulls the last entry into it; then remove the tail itself.
      post_req(FUNC_REMOVE, 0, 0, 0);
      post_req(FUNC_REMOVE, 63, 63, 0);
      post_req(FUNC_NOP, 42, 21, 32'sh5555_aaaa);
      post_req(FUNC_CLEAR, 0, 0, 0);

      // A zero board allows no entries: appends report full, set and merge off board.
      write_board(0);
      post_req(FUNC_ADD, 0, 0, 9);
      post_req(FUNC_SET, 0, 0, 9);
      post_req(FUNC_MERGE, 0, 0, 9);

      // A two by two board holds four entries. Once it is full, an on-board set reports
      // full, while an off-board set still reports off board first.
      write_board(2);
      post_req(FUNC_ADD, 5, 5, 1);
      post_req(FUNC_ADD, 6, 6, 2);
      post_req(FUNC_ADD, 7, 7, 3);
      post_req(FUNC_ADD, 1, 0, 4);
      post_req(FUNC_SET, 1, 1, 5);
      post_req(FUNC_SET, 9, 9, 6);

      // Random traffic on a small board that fills up often.
      write_board(4);
      post_req(FUNC_CLEAR, 0, 0, 0);
      post_mixed(180, 5);

      write_board(1);
      post_mixed(50, 2);

      // Phase two: the roles swap. The receiver also holds off for a long stretch while
      // beats keep coming, which backs the block up into its request port.
      send_idle_pct = 55;
      recv_idle_pct = 6;
      write_board(63);
      post_mixed(180, 10);
      pressure_kicks++;

      write_board(7);
      post_mixed(120, 8);

      // Phase three: no pauses on either side. Fill the table to its hard capacity on the
      // largest board, try a few appends beyond it, then work on the full table.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_board(63);
      post_req(FUNC_CLEAR, 0, 0, 0);
      for (int i = 0; i < TBL_DEPTH + 3; i++) begin
         post_req(FUNC_ADD, COORD_W'(i % 64), COORD_W'(i / 64), pick_weight());
      end
      for (int i = 0; i < 25; i++) begin
         k = $urandom_range(0, TBL_DEPTH + 18);
         case ($urandom_range(0, 5))
            0: f = FUNC_ADD;
            1: f = FUNC_SET;
            2: f = FUNC_MERGE;
            3: f = FUNC_REMOVE;
            4: f = FUNC_LOOKUP;
            default: f = FUNC_RANGE;
         endcase
         post_req(f, COORD_W'(k % 64), COORD_W'(k / 64), pick_weight());
      end

      write_board(12);
      post_mixed(80, 13);

      // Let any stray result beat show up before the verdict.
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
